[src/biquad_bandpass_filter_defines.svh]
// Assertion macros for the biquad band-pass filter checker.
// Assumes clk_i and rst_ni are visible where the macros are used.
`ifndef BIQUAD_BANDPASS_FILTER_DEFINES_SVH
`define BIQUAD_BANDPASS_FILTER_DEFINES_SVH

// Generic clocked property, disabled while in reset
`define BQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal must hold while its channel is stalled
`define BQ_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

[src/bq_pkg.sv]
// Shared widths, register codes and types for the biquad band-pass filter.
// No dependencies.
`timescale 1ns / 1ps

package bq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int FRAC_W    = COEF_W - 3;          // Q3.x coefficients
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int SUM_W     = PROD_W + 2;          // four products
  localparam int Q_W       = SUM_W - FRAC_W;
  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int WARMUP    = 2;
  localparam int WARM_W    = $clog2(WARMUP + 1);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Coefficient register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PREV_OUT1 = 2'd0,
    REG_PREV_OUT2 = 2'd1,
    REG_IN_NOW    = 2'd2,
    REG_IN_PREV2  = 2'd3
  } bq_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } bq_result_t;

endpackage

[src/bq_ifs.sv]
// Handshake interfaces for the sample, result and coefficient channels.
// Depends on bq_pkg.
`timescale 1ns / 1ps

interface bq_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [bq_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface bq_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [bq_pkg::SAMPLE_W-1:0] filtered;
  logic                               clipped;
  modport source (output valid, filtered, clipped, input ready);
  modport sink   (input valid, filtered, clipped, output ready);
endinterface

interface bq_cfg_if;
  logic                                valid;
  logic                                ready;
  logic        [bq_pkg::REG_IDX_W-1:0] index;
  logic signed [bq_pkg::COEF_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/biquad_bandpass_filter.sv]
// Biquad band-pass filter: one sample in, one filtered sample out.
// Depends on bq_pkg and the interfaces in bq_ifs.sv.
//
//   channel    dir   payload                      accepted when
//   sample_if  in    sample (s16)                 valid && ready
//   result_if  out   filtered (s16), clipped      valid && ready
//   cfg_if     in    index (2b), data (s24 Q3.21) valid && ready (ready always 1)
//
// One item per cycle while the skid is empty; results are registered in the output
// register or the skid. The recursion on the previous output closes through four
// 24x16 multipliers and one adder into the history and result registers.
// A two-entry result buffer (output register plus skid) lets input continue for
// one item while the output stalls. Reset clears coefficients, histories and
// the warm-up count; a coefficient write clears histories and warm-up.
`timescale 1ns / 1ps

module biquad_bandpass_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  bq_sample_if.sink     sample_if,
  bq_result_if.source   result_if,
  bq_cfg_if.sink        cfg_if
);

  // Coefficients and filter state
  logic signed [bq_pkg::COEF_W-1:0]   coef_q [bq_pkg::NUM_REGS];
  logic signed [bq_pkg::SAMPLE_W-1:0] in_h1_q, in_h2_q, out_h1_q, out_h2_q;
  logic        [bq_pkg::WARM_W-1:0]   warm_cnt_q;

  // Result buffer
  bq_pkg::bq_result_t out_q, out_d, skid_q, skid_d;
  logic               out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  logic               cfg_wr, in_acc, out_take, warming;
  bq_pkg::bq_result_t res;

  localparam logic signed [bq_pkg::SUM_W-1:0] RND =
    bq_pkg::SUM_W'(1) <<< (bq_pkg::FRAC_W - 1);

  logic signed [bq_pkg::PROD_W-1:0] p0, p1, p2, p3;
  logic signed [bq_pkg::SUM_W-1:0]  acc_sum;
  logic signed [bq_pkg::Q_W-1:0]    q_val;

  assign cfg_if.ready    = 1'b1;
  assign cfg_wr          = cfg_if.valid;
  assign sample_if.ready = !skid_vld_q;
  assign in_acc          = sample_if.valid && !skid_vld_q;
  assign out_take        = out_vld_q && result_if.ready;
  assign warming         = warm_cnt_q < bq_pkg::WARM_W'(bq_pkg::WARMUP);

  // Multiply-accumulate with round-half-up and saturation; warm-up passes the input
  assign p0      = coef_q[bq_pkg::REG_PREV_OUT1] * out_h1_q;
  assign p1      = coef_q[bq_pkg::REG_PREV_OUT2] * out_h2_q;
  assign p2      = coef_q[bq_pkg::REG_IN_NOW]    * sample_if.sample;
  assign p3      = coef_q[bq_pkg::REG_IN_PREV2]  * in_h2_q;
  assign acc_sum = bq_pkg::SUM_W'(p0) + bq_pkg::SUM_W'(p1)
                 + bq_pkg::SUM_W'(p2) + bq_pkg::SUM_W'(p3) + RND;
  assign q_val   = bq_pkg::Q_W'(acc_sum >>> bq_pkg::FRAC_W);

  always_comb begin
    if (warming) begin
      res.filtered = sample_if.sample;
      res.clipped  = 1'b0;
    end else if (q_val > bq_pkg::SAMPLE_MAX) begin
      res.filtered = bq_pkg::SAMPLE_MAX;
      res.clipped  = 1'b1;
    end else if (q_val < bq_pkg::SAMPLE_MIN) begin
      res.filtered = bq_pkg::SAMPLE_MIN;
      res.clipped  = 1'b1;
    end else begin
      res.filtered = q_val[bq_pkg::SAMPLE_W-1:0];
      res.clipped  = 1'b0;
    end
  end

  // Coefficients, histories, warm-up count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bq_pkg::NUM_REGS; i++) coef_q[i] <= '0;
      in_h1_q    <= '0;
      in_h2_q    <= '0;
      out_h1_q   <= '0;
      out_h2_q   <= '0;
      warm_cnt_q <= '0;
    end else if (cfg_wr) begin
      unique case (bq_pkg::bq_reg_e'(cfg_if.index))
        bq_pkg::REG_PREV_OUT1: coef_q[bq_pkg::REG_PREV_OUT1] <= cfg_if.data;
        bq_pkg::REG_PREV_OUT2: coef_q[bq_pkg::REG_PREV_OUT2] <= cfg_if.data;
        bq_pkg::REG_IN_NOW:    coef_q[bq_pkg::REG_IN_NOW]    <= cfg_if.data;
        bq_pkg::REG_IN_PREV2:  coef_q[bq_pkg::REG_IN_PREV2]  <= cfg_if.data;
        default: ;
      endcase
      in_h1_q    <= '0;
      in_h2_q    <= '0;
      out_h1_q   <= '0;
      out_h2_q   <= '0;
      warm_cnt_q <= '0;
    end else if (in_acc) begin
      in_h2_q  <= in_h1_q;
      in_h1_q  <= sample_if.sample;
      out_h2_q <= out_h1_q;
      out_h1_q <= res.filtered;
      if (warming) warm_cnt_q <= warm_cnt_q + 1'b1;
    end
  end

  // Result buffer: output slot refills from skid first, then from a new item
  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_take) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_if.valid    = out_vld_q;
  assign result_if.filtered = out_q.filtered;
  assign result_if.clipped  = out_q.clipped;

endmodule

[src/bq_checker.sv]
// Port-level checks for the biquad band-pass filter, bound to the top level.
// Depends on bq_pkg and biquad_bandpass_filter_defines.svh.
`timescale 1ns / 1ps
`include "biquad_bandpass_filter_defines.svh"

module bq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [bq_pkg::SAMPLE_W-1:0] filtered_i,
  input logic                               clipped_i
);

  logic in_acc, out_stall;
  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // a stalled result keeps its value
  `BQ_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, filtered_i, "result changed while stalled")

  // a clipped result sits at one of the rails
  `BQ_ASSERT(a_clip_rail, clipped_i && out_valid_i |-> (filtered_i == bq_pkg::SAMPLE_MAX || filtered_i == bq_pkg::SAMPLE_MIN), "clipped result off the rails")

  // an item taken while the output is empty shows up next cycle
  `BQ_ASSERT(a_latency, in_acc && !out_valid_i |=> out_valid_i, "result missing one cycle after item")

  // with the output stalled, one more item fills the skid and input stops
  `BQ_ASSERT(a_skid_full, out_stall && in_acc |=> !in_ready_i, "input ready with skid full")

endmodule

bind biquad_bandpass_filter bq_checker u_bq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_if.valid),
  .in_ready_i  (sample_if.ready),
  .out_valid_i (result_if.valid),
  .out_ready_i (result_if.ready),
  .filtered_i  (result_if.filtered),
  .clipped_i   (result_if.clipped)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for biquad_bandpass_filter: a directed table, then random phases
// of coefficient settings and samples. Depends on bq_pkg, the interfaces in bq_ifs.sv and the RTL.

module tb;
  import bq_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int QUIET_TAIL    = 150;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic signed [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << FRAC_W;
  localparam logic signed [COEF_W-1:0] COEF_HALF = COEF_W'(1) << (FRAC_W - 1);

  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_e;
  typedef enum {MODE_BANDPASS, MODE_WILD, MODE_EDGE} coef_mode_e;

  typedef struct {
    row_kind_e                  kind;
    bq_reg_e                    reg_idx;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         typed;
    bq_result_t                 result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  bq_sample_if sample_if ();
  bq_result_if result_if ();
  bq_cfg_if    cfg_if ();

  biquad_bandpass_filter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_if (sample_if),
    .result_if (result_if),
    .cfg_if    (cfg_if)
  );

  // Filter state mirrored by the checker
  logic signed [COEF_W-1:0]   coef_q [NUM_REGS];
  logic signed [SAMPLE_W-1:0] x_d1, x_d2, y_d1, y_d2;
  int                         warm_cnt;

  bq_result_t expected_q [$];
  stim_row_t  directed [$];
  bq_result_t head;
  int         errors = 0;
  int         cycles;
  bit         quiet = 1'b0;
  bit         long_hold_req = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  task automatic clear_taps();
    x_d1 = '0;
    x_d2 = '0;
    y_d1 = '0;
    y_d2 = '0;
    warm_cnt = 0;
  endtask

  // Expected output for one sample; advances the history
  function automatic bq_result_t next_filtered(input logic signed [SAMPLE_W-1:0] x);
    longint     acc;
    bq_result_t r;
    r.clipped = 1'b0;
    if (warm_cnt < WARMUP) begin
      r.filtered = x;
      warm_cnt++;
    end else begin
      acc = longint'(coef_q[REG_PREV_OUT1]) * longint'(y_d1)
          + longint'(coef_q[REG_PREV_OUT2]) * longint'(y_d2)
          + longint'(coef_q[REG_IN_NOW])    * longint'(x)
          + longint'(coef_q[REG_IN_PREV2])  * longint'(x_d2);
      // round half up, then drop the Q3.21 fraction
      acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      if (acc > longint'(SAMPLE_MAX)) begin
        r.filtered = SAMPLE_MAX;
        r.clipped  = 1'b1;
      end else if (acc < longint'(SAMPLE_MIN)) begin
        r.filtered = SAMPLE_MIN;
        r.clipped  = 1'b1;
      end else begin
        r.filtered = acc[SAMPLE_W-1:0];
      end
    end
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = r.filtered;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic add_sample(input int s, input bit typed = 1'b0,
                            input int f = 0, input bit c = 1'b0);
    stim_row_t row;
    row.kind            = ROW_SAMPLE;
    row.reg_idx         = REG_PREV_OUT1;
    row.coef            = '0;
    row.sample          = SAMPLE_W'(s);
    row.typed           = typed;
    row.result.filtered = SAMPLE_W'(f);
    row.result.clipped  = c;
    directed.push_back(row);
  endtask

  task automatic add_cfg(input bq_reg_e idx, input logic signed [COEF_W-1:0] val);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.coef    = val;
    row.sample  = '0;
    row.typed   = 1'b0;
    row.result  = '0;
    directed.push_back(row);
  endtask

  // Offer one sample; optional gap first. Typed rows push their own expectation.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                             input bq_result_t want);
    bq_result_t calc;
    if (cfg_if.valid === 1'b1) cfg_if.valid <= 1'b0;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= s;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    calc = next_filtered(s);
    expected_q.push_back(typed ? want : calc);
  endtask

  // Coefficient write; valid stays high for back-to-back writes
  task automatic write_coef(input bq_reg_e idx, input logic signed [COEF_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    coef_q[idx] = val;
    clear_taps();
  endtask

  // Stop offering samples until every pending result has come out
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result receiver: random stall bursts, one long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        result_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
        result_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ERROR: unexpected item, expected none actual filtered=%0d clipped=%0b",
                 $time, result_if.filtered, result_if.clipped);
      end else begin
        head = expected_q.pop_front();
        if (head.filtered !== result_if.filtered) begin
          errors++;
          $display("%0t ERROR: filtered expected %0d actual %0d",
                   $time, head.filtered, result_if.filtered);
        end
        if (head.clipped !== result_if.clipped) begin
          errors++;
          $display("%0t ERROR: clipped expected %0b actual %0b",
                   $time, head.clipped, result_if.clipped);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  // Stimulus
  initial begin
    logic signed [COEF_W-1:0] plan [NUM_REGS];
    coef_mode_e               mode;
    stim_row_t                row;
    bq_result_t               none;
    int                       done_items;
    int                       phase;
    int                       n;
    int                       tmp;
    bit                       any;

    rst_ni           <= 1'b0;
    sample_if.valid  <= 1'b0;
    sample_if.sample <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_PREV_OUT1;
    cfg_if.data      <= '0;
    none = '0;
    for (int r = 0; r < NUM_REGS; r++) coef_q[r] = '0;
    clear_taps();

    // reset gains: warm-up passes the input, then zero gains give zero
    add_sample(32767, 1, 32767, 0);
    add_sample(-32768, 1, -32768, 0);
    add_sample(1234, 1, 0, 0);
    add_sample(-1, 1, 0, 0);
    // largest gain on the current input: both rails clip
    add_cfg(REG_IN_NOW, COEF_MAX);
    add_sample(0, 1, 0, 0);
    add_sample(0, 1, 0, 0);
    add_sample(32767, 1, 32767, 1);
    add_sample(-32768, 1, -32768, 1);
    add_sample(100);
    // extreme gains on every tap
    add_cfg(REG_PREV_OUT1, COEF_MIN);
    add_cfg(REG_PREV_OUT2, COEF_MAX);
    add_cfg(REG_IN_NOW, COEF_MIN);
    add_cfg(REG_IN_PREV2, COEF_MAX);
    add_sample(32767, 1, 32767, 0);
    add_sample(-32768, 1, -32768, 0);
    add_sample(1);
    add_sample(-1);
    add_sample(12345);
    add_sample(-32768);
    // half gain on the input alone: ties round up
    add_cfg(REG_PREV_OUT1, '0);
    add_cfg(REG_PREV_OUT2, '0);
    add_cfg(REG_IN_PREV2, '0);
    add_cfg(REG_IN_NOW, COEF_HALF);
    add_sample(0, 1, 0, 0);
    add_sample(0, 1, 0, 0);
    add_sample(1, 1, 1, 0);
    add_sample(-1, 1, 0, 0);
    add_sample(3, 1, 2, 0);
    add_sample(-3, 1, -1, 0);
    add_sample(32767, 1, 16384, 0);
    add_sample(-32768, 1, -16384, 0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) begin
        if (i > 0 && directed[i-1].kind != ROW_CFG) drain();
        write_coef(row.reg_idx, row.coef);
      end else begin
        send_sample(row.sample, row.typed, row.result);
      end
    end

    // random phases: new gains, then a run of samples
    done_items = 0;
    phase      = 0;
    while (done_items < RANDOM_ITEMS) begin
      drain();
      tmp  = $urandom_range(0, 9);
      mode = (tmp < 6) ? MODE_BANDPASS : ((tmp < 8) ? MODE_WILD : MODE_EDGE);
      case (mode)
        MODE_BANDPASS: begin
          // stable pole pair, zeros at DC and Nyquist
          tmp = int'($urandom_range(0, 3145727));
          if ($urandom_range(0, 1) == 1) tmp = -tmp;
          plan[REG_PREV_OUT1] = COEF_W'(tmp);
          plan[REG_PREV_OUT2] = COEF_W'(-int'($urandom_range(1048576, 2076180)));
          tmp = int'($urandom_range(0, 1 << 20));
          plan[REG_IN_NOW]   = COEF_W'(tmp);
          plan[REG_IN_PREV2] = COEF_W'(-tmp);
        end
        MODE_WILD: begin
          for (int r = 0; r < NUM_REGS; r++) plan[r] = COEF_W'($urandom());
        end
        default: begin
          for (int r = 0; r < NUM_REGS; r++) begin
            case ($urandom_range(0, 4))
              0:       plan[r] = COEF_MAX;
              1:       plan[r] = COEF_MIN;
              2:       plan[r] = '0;
              3:       plan[r] = COEF_ONE;
              default: plan[r] = '1;
            endcase
          end
        end
      endcase
      any = 1'b0;
      for (int r = 0; r < NUM_REGS; r++) begin
        if ($urandom_range(0, 3) != 0 || (r == NUM_REGS - 1 && !any)) begin
          write_coef(bq_reg_e'(r), plan[r]);
          any = 1'b1;
        end
      end

      // output held off for a long stretch while samples keep coming
      if (phase == 2) long_hold_req = 1'b1;
      n = $urandom_range(40, 160);
      for (int k = 0; k < n && done_items < RANDOM_ITEMS; k++) begin
        if (phase == 4 && k == n / 2) drain();
        quiet = (done_items >= RANDOM_ITEMS - QUIET_TAIL);
        send_sample(rand_sample(), 1'b0, none);
        done_items++;
      end
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bq_pkg.sv
src/bq_ifs.sv
src/biquad_bandpass_filter.sv
src/bq_checker.sv
verif/tb.sv
